// File: design/momentum_curvature_weight_update_unit_assert.svh
// Assertion macros shared by the momentum and curvature update design.
`ifndef MOMENTUM_CURVATURE_WEIGHT_UPDATE_UNIT_ASSERT_SVH
`define MOMENTUM_CURVATURE_WEIGHT_UPDATE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define MCWU_ASSERT_NOW(lbl, ant, con) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
        else $error("assertion failed");
`define MCWU_ASSERT_NEXT(lbl, ant, con) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
        else $error("assertion failed");
`else
`define MCWU_ASSERT_NOW(lbl, ant, con)
`define MCWU_ASSERT_NEXT(lbl, ant, con)
`endif
`endif

// File: design/mcwu_pkg.sv
`timescale 1ns / 1ps
package mcwu_pkg;

    localparam int NUM_PARAMS = 4096;
    localparam int IDX_W = $clog2(NUM_PARAMS);
    localparam int DATA_W = 32;
    localparam int FRAC_BITS = 16;
    localparam int COEF_BITS = 16;
    localparam int LR_W = 16;
    localparam int DECAY_W = 17;
    localparam int WIDE_W = 50;
    localparam int DIV_W = DATA_W + FRAC_BITS;
    localparam int DIVISOR_W = DATA_W - 1;

    localparam logic [LR_W-1:0] LR_RESET = LR_W'(655);
    localparam logic [DECAY_W-1:0] DECAY_RESET = DECAY_W'(58982);
    localparam logic [DECAY_W-1:0] DECAY_ONE = DECAY_W'(65536);
    localparam logic [DATA_W-1:0] CURV_ONE = DATA_W'(1) << FRAC_BITS;

    typedef enum logic [0:0] {
        REG_LEARNING_RATE = 1'b0,
        REG_DECAY_FACTOR  = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic ovf;
        logic signed [DATA_W-1:0] val;
    } sat_t;

    typedef struct packed {
        logic valid;
        logic neg;
        logic [DATA_W-1:0] m_mag;
        logic [DIVISOR_W-1:0] divisor;
        logic signed [DATA_W-1:0] weight;
        logic flag;
    } div_in_t;

    typedef struct packed {
        logic valid;
        logic neg;
        logic [DIV_W-1:0] quot;
        logic signed [DATA_W-1:0] weight;
        logic flag;
    } div_out_t;

    function automatic sat_t sat32(input logic signed [WIDE_W-1:0] x);
        sat_t r;
        if (x > $signed(WIDE_W'(64'sh7FFFFFFF)))
        begin
            r.ovf = 1'b1;
            r.val = 32'sh7FFFFFFF;
        end
        else if (x < $signed(WIDE_W'(-64'sh80000000)))
        begin
            r.ovf = 1'b1;
            r.val = 32'sh80000000;
        end
        else
        begin
            r.ovf = 1'b0;
            r.val = x[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: design/mcwu_ram.sv
`timescale 1ns / 1ps
module mcwu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: design/mcwu_acc.sv
`timescale 1ns / 1ps
`include "momentum_curvature_weight_update_unit_assert.svh"
module mcwu_acc (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              accept,
    input  logic [mcwu_pkg::IDX_W-1:0]        in_idx,
    input  logic signed [mcwu_pkg::DATA_W-1:0] in_weight,
    input  logic signed [mcwu_pkg::DATA_W-1:0] in_grad,
    input  logic [mcwu_pkg::DECAY_W-1:0]      decay,
    output logic                              clearing,
    output logic                              hazard,
    output mcwu_pkg::div_in_t                 div_in
);

    localparam int W = mcwu_pkg::DATA_W;
    localparam int IW = mcwu_pkg::IDX_W;
    localparam int XW = mcwu_pkg::WIDE_W;

    logic clear_reg, clear_next;
    logic [IW-1:0] clr_cnt_reg, clr_cnt_next;

    logic v1_reg, v2_reg;
    logic [IW-1:0] idx1_reg, idx2_reg;
    logic signed [W-1:0] w1_reg, w2_reg, g1_reg, g2_reg;
    logic signed [XW-1:0] pm_reg, pc_reg;
    logic [2*W-1:0] gg_reg;
    mcwu_pkg::div_in_t out_reg;
    logic vo_reg;

    logic [W-1:0] m_rdata, c_rdata;
    logic ram_we;
    logic [IW-1:0] ram_waddr;
    logic [W-1:0] m_wdata, c_wdata;

    logic signed [XW-1:0] pm_next, pc_next;
    logic [2*W-1:0] gg_next;
    logic [W-1:0] g_mag;

    logic [2*W-mcwu_pkg::FRAC_BITS-1:0] gsq;
    logic signed [XW-1:0] sq, m_sum, c_sum;
    mcwu_pkg::sat_t m_sat, c_sat;
    logic signed [W-1:0] c_val;
    mcwu_pkg::div_in_t out_next;

    always_comb
    begin
        clear_next = clear_reg;
        clr_cnt_next = clr_cnt_reg;
        if (clear_reg)
        begin
            clr_cnt_next = clr_cnt_reg + IW'(1);
            if (clr_cnt_reg == IW'(mcwu_pkg::NUM_PARAMS - 1))
            begin
                clear_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg <= 1'b1;
            clr_cnt_reg <= '0;
        end
        else
        begin
            clear_reg <= clear_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    assign clearing = clear_reg;
    assign hazard = (v1_reg && (idx1_reg == in_idx)) || (v2_reg && (idx2_reg == in_idx));

    always_comb
    begin
        g_mag = g1_reg[W-1] ? (~g1_reg + W'(1)) : g1_reg;
        pm_next = $signed(m_rdata) * $signed({1'b0, decay});
        pc_next = $signed(c_rdata) * $signed({1'b0, decay});
        gg_next = g_mag * g_mag;
    end

    always_comb
    begin
        gsq = gg_reg[2*W-1:mcwu_pkg::FRAC_BITS];
        if (gsq > (2*W-mcwu_pkg::FRAC_BITS)'(32'h7FFFFFFF))
        begin
            sq = XW'(64'sh80000000);
        end
        else
        begin
            sq = $signed({2'b00, gsq});
        end
        m_sum = (pm_reg >>> mcwu_pkg::COEF_BITS) + XW'(g2_reg);
        c_sum = (pc_reg >>> mcwu_pkg::COEF_BITS) + sq;
        m_sat = mcwu_pkg::sat32(m_sum);
        c_sat = mcwu_pkg::sat32(c_sum);
        c_val = c_sat.val[W-1] ? '0 : c_sat.val;
        out_next.valid = v2_reg;
        out_next.neg = m_sat.val[W-1];
        out_next.m_mag = m_sat.val[W-1] ? (~m_sat.val + W'(1)) : m_sat.val;
        out_next.divisor = (c_val == '0) ? mcwu_pkg::DIVISOR_W'(1) : c_val[W-2:0];
        out_next.weight = w2_reg;
        out_next.flag = m_sat.ovf | c_sat.ovf;
    end

    always_comb
    begin
        if (clear_reg)
        begin
            ram_we = 1'b1;
            ram_waddr = clr_cnt_reg;
            m_wdata = '0;
            c_wdata = mcwu_pkg::CURV_ONE;
        end
        else
        begin
            ram_we = en && v2_reg;
            ram_waddr = idx2_reg;
            m_wdata = m_sat.val;
            c_wdata = c_val;
        end
    end

    mcwu_ram #(.WIDTH(W), .DEPTH(mcwu_pkg::NUM_PARAMS)) u_mom_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (m_wdata),
        .re    (accept),
        .raddr (in_idx),
        .rdata (m_rdata)
    );

    mcwu_ram #(.WIDTH(W), .DEPTH(mcwu_pkg::NUM_PARAMS)) u_curv_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (c_wdata),
        .re    (accept),
        .raddr (in_idx),
        .rdata (c_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            vo_reg <= out_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            idx1_reg <= in_idx;
            w1_reg <= in_weight;
            g1_reg <= in_grad;
            idx2_reg <= idx1_reg;
            w2_reg <= w1_reg;
            g2_reg <= g1_reg;
            pm_reg <= pm_next;
            pc_reg <= pc_next;
            gg_reg <= gg_next;
            out_reg <= out_next;
        end
    end

    always_comb
    begin
        div_in = out_reg;
        div_in.valid = vo_reg;
    end

    `MCWU_ASSERT_NOW(a_no_raw_s1, accept && v1_reg, in_idx != idx1_reg)
    `MCWU_ASSERT_NOW(a_no_raw_s2, accept && v2_reg, in_idx != idx2_reg)
    `MCWU_ASSERT_NOW(a_clear_idle, clear_reg, !accept && !v1_reg && !v2_reg)
    `MCWU_ASSERT_NEXT(a_accept_s1, accept, v1_reg)

endmodule

// File: design/mcwu_div.sv
`timescale 1ns / 1ps
module mcwu_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  mcwu_pkg::div_in_t  div_in,
    output mcwu_pkg::div_out_t div_out
);

    localparam int S = mcwu_pkg::DIV_W;
    localparam int W = mcwu_pkg::DATA_W;
    localparam int DW = mcwu_pkg::DIVISOR_W;

    logic [S-1:0] v_reg;
    logic [W-1:0] rem_reg [S];
    logic [S-1:0] num_reg [S];
    logic [DW-1:0] dvs_reg [S];
    logic neg_reg [S];
    logic signed [W-1:0] w_reg [S];
    logic flag_reg [S];

    logic [W-1:0] rem_in [S];
    logic [S-1:0] num_in [S];
    logic [DW-1:0] dvs_in [S];
    logic [W-1:0] rem_next [S];
    logic [S-1:0] num_next [S];
    logic [W-1:0] shifted [S];
    logic ge [S];

    always_comb
    begin
        rem_in[0] = '0;
        num_in[0] = {div_in.m_mag, mcwu_pkg::FRAC_BITS'(0)};
        dvs_in[0] = div_in.divisor;
        for (int k = 1; k < S; k++)
        begin
            rem_in[k] = rem_reg[k-1];
            num_in[k] = num_reg[k-1];
            dvs_in[k] = dvs_reg[k-1];
        end
        for (int k = 0; k < S; k++)
        begin
            shifted[k] = {rem_in[k][W-2:0], num_in[k][S-1]};
            ge[k] = shifted[k] >= {1'b0, dvs_in[k]};
            rem_next[k] = ge[k] ? (shifted[k] - {1'b0, dvs_in[k]}) : shifted[k];
            num_next[k] = {num_in[k][S-2:0], ge[k]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[S-2:0], div_in.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < S; k++)
            begin
                rem_reg[k] <= rem_next[k];
                num_reg[k] <= num_next[k];
                dvs_reg[k] <= dvs_in[k];
            end
            neg_reg[0] <= div_in.neg;
            w_reg[0] <= div_in.weight;
            flag_reg[0] <= div_in.flag;
            for (int k = 1; k < S; k++)
            begin
                neg_reg[k] <= neg_reg[k-1];
                w_reg[k] <= w_reg[k-1];
                flag_reg[k] <= flag_reg[k-1];
            end
        end
    end

    assign div_out.valid = v_reg[S-1];
    assign div_out.neg = neg_reg[S-1];
    assign div_out.quot = num_reg[S-1];
    assign div_out.weight = w_reg[S-1];
    assign div_out.flag = flag_reg[S-1];

endmodule

// File: design/momentum_curvature_weight_update_unit.sv
`timescale 1ns / 1ps
// One word per cycle is accepted while the output does not stall and no index
// hazard or clearing pass holds the input; the divider is a 48-stage pipeline.
// A word whose index matches one of the two words still in the read-modify-write
// window waits until that write lands.
// After reset a clearing pass initializes both state memories.
module momentum_curvature_weight_update_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [0:0]                          cfg_index,
    input  logic [mcwu_pkg::DECAY_W-1:0]        cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [mcwu_pkg::IDX_W-1:0]          param_index,
    input  logic signed [mcwu_pkg::DATA_W-1:0]  weight_in,
    input  logic signed [mcwu_pkg::DATA_W-1:0]  gradient,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [mcwu_pkg::DATA_W-1:0]  weight_out,
    output logic                                saturated
);

    localparam int W = mcwu_pkg::DATA_W;
    localparam int XW = mcwu_pkg::WIDE_W;

    logic [mcwu_pkg::LR_W-1:0] lr_reg;
    logic [mcwu_pkg::DECAY_W-1:0] decay_reg;
    logic [mcwu_pkg::DECAY_W-1:0] decay_eff;

    logic en, accept, clearing, hazard;
    mcwu_pkg::div_in_t div_in;
    mcwu_pkg::div_out_t div_out;

    logic va_reg, vb_reg, vc_reg;
    logic signed [W-1:0] delta_reg, wa_reg, wb_reg;
    logic fa_reg, fb_reg;
    logic signed [XW-1:0] prod_reg;
    logic signed [W-1:0] wout_reg;
    logic sat_reg;

    logic signed [XW-1:0] q_wide, prod_next, wn;
    mcwu_pkg::sat_t q_sat, st_sat, w_sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lr_reg <= mcwu_pkg::LR_RESET;
            decay_reg <= mcwu_pkg::DECAY_RESET;
        end
        else if (cfg_we)
        begin
            unique case (mcwu_pkg::cfg_reg_t'(cfg_index))
                mcwu_pkg::REG_LEARNING_RATE: lr_reg <= cfg_data[mcwu_pkg::LR_W-1:0];
                mcwu_pkg::REG_DECAY_FACTOR:  decay_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign decay_eff = (decay_reg > mcwu_pkg::DECAY_ONE) ? mcwu_pkg::DECAY_ONE : decay_reg;

    assign en = !vc_reg || out_ready;
    assign in_ready = en && !clearing && !hazard;
    assign accept = in_valid && in_ready;

    mcwu_acc u_acc (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .accept    (accept),
        .in_idx    (param_index),
        .in_weight (weight_in),
        .in_grad   (gradient),
        .decay     (decay_eff),
        .clearing  (clearing),
        .hazard    (hazard),
        .div_in    (div_in)
    );

    mcwu_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .div_in  (div_in),
        .div_out (div_out)
    );

    always_comb
    begin
        q_wide = div_out.neg ? -$signed({2'b00, div_out.quot})
                             : $signed({2'b00, div_out.quot});
        q_sat = mcwu_pkg::sat32(q_wide);
        prod_next = $signed({1'b0, lr_reg}) * delta_reg;
        st_sat = mcwu_pkg::sat32(prod_reg >>> mcwu_pkg::COEF_BITS);
        wn = XW'(wb_reg) - XW'(st_sat.val);
        w_sat = mcwu_pkg::sat32(wn);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= div_out.valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            delta_reg <= q_sat.val;
            wa_reg <= div_out.weight;
            fa_reg <= div_out.flag | q_sat.ovf;
            prod_reg <= prod_next;
            wb_reg <= wa_reg;
            fb_reg <= fa_reg;
            wout_reg <= w_sat.val;
            sat_reg <= fb_reg | st_sat.ovf | w_sat.ovf;
        end
    end

    assign out_valid = vc_reg;
    assign weight_out = wout_reg;
    assign saturated = sat_reg;

endmodule
